// ----- src/bba_pkg.sv -----
// Package for the bitmap block allocator: request/status codes, defaults,
// and the front-to-back command struct. No dependencies.
package bba_pkg;
    localparam int unsigned NUM_WORDS_DEF = 64;
    localparam int unsigned WORD_BITS_DEF = 64;
    localparam logic [15:0] MIN_RESET = 16'd0;
    localparam logic [15:0] MAX_RESET = 16'd4095;

    typedef enum logic [1:0] {
        MODE_GET   = 2'd0,
        MODE_SET   = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_FIND  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic {
        CFG_MIN = 1'b0,
        CFG_MAX = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_RD,
        BK_WAIT,
        BK_EXEC,
        BK_SCAN,
        BK_CLR
    } t_bk_state;

    // Classified command handed from front to back (word/bit widths max-sized).
    typedef struct packed {
        t_mode       mode;
        logic        bad;
        logic [10:0] word;
        logic [5:0]  bit_ofs;
    } t_cmd;
endpackage

// ----- src/bitmap_block_allocator_core.sv -----
// Top level of the bitmap block allocator: config registers, front end,
// queue and back end. Depends on bba_pkg, bba_front, bba_back.
//
//  port group        | direction | transfer when
//  i_start/o_busy    | in        | i_start && !o_busy
//  i_cfg_*           | in        | i_cfg_valid && o_cfg_ready
//  o_strobe results  | out       | o_strobe (one cycle, no stall)
//
// get/set/clear: from transfer to strobe through queue, RAM read and execute;
// an out-of-range index goes from the queue to the strobe without a RAM read.
// find: scans from the cursor past all-ones words; full without a RAM read if the cursor is at the end.
// After reset a clearing pass over all NUM_WORDS words holds o_busy high.
// The front queue holds two requests; o_busy rises when it is full.
module bitmap_block_allocator_core import bba_pkg::*; #(
    parameter int unsigned NUM_WORDS = NUM_WORDS_DEF,
    parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_index,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic        o_bit_value,
    output logic [15:0] o_free_index
);
    logic [15:0] r_min, r_max;
    logic        q_full, q_valid, pop, bk_busy;
    t_cmd        cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_RESET;
            r_max <= MAX_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MIN: r_min <= i_cfg_data;
                default: r_max <= i_cfg_data;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_busy = q_full || bk_busy;

    bba_front #(.NUM_WORDS(NUM_WORDS), .WORD_BITS(WORD_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_start && !o_busy),
        .i_mode(i_mode), .i_index(i_index), .i_min(r_min), .i_max(r_max),
        .o_full(q_full), .o_valid(q_valid), .o_cmd(cmd), .i_pop(pop)
    );

    bba_back #(.NUM_WORDS(NUM_WORDS), .WORD_BITS(WORD_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_cmd(cmd),
        .o_pop(pop), .o_busy(bk_busy), .i_min(r_min), .i_max(r_max),
        .o_strobe(o_strobe), .o_status(o_status), .o_bit_value(o_bit_value),
        .o_free_index(o_free_index)
    );
endmodule

// ----- src/bba_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module bba_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ----- src/bba_front.sv -----
// Front end: takes requests, range-checks the index, splits word/bit,
// and pushes a command into a two-entry queue. Depends on bba_pkg.
module bba_front import bba_pkg::*; #(
    parameter int unsigned NUM_WORDS = NUM_WORDS_DEF,
    parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_index,
    input  logic [15:0] i_min,
    input  logic [15:0] i_max,
    output logic        o_full,
    output logic        o_valid,
    output t_cmd        o_cmd,
    input  logic        i_pop
);
    localparam int unsigned BW = $clog2(WORD_BITS);

    logic [15:0] rel;
    logic [15:0] wrd;
    logic        bad;
    t_cmd        cmd_in;
    t_cmd        r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        n_wp, n_rp;
    logic [1:0]  n_cnt;

    always_comb begin
        rel = i_index - i_min;
        wrd = rel >> BW;
        bad = (i_index < i_min) || (i_index > i_max) || ({16'd0, wrd} >= 32'(NUM_WORDS));
        cmd_in.mode = t_mode'(i_mode);
        cmd_in.bad = bad;
        cmd_in.word = wrd[10:0];
        cmd_in.bit_ofs = 6'(rel & 16'(WORD_BITS - 1));
        n_wp = r_wp ^ i_push;
        n_rp = r_rp ^ i_pop;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    assign o_full = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd = r_q[r_rp];
endmodule

// ----- src/bba_back.sv -----
// Back end: clears the bitmap after reset, executes get as a read and set/clear as a
// read-modify-write, and scans words for find. Depends on bba_pkg, bba_ram.
module bba_back import bba_pkg::*; #(
    parameter int unsigned NUM_WORDS = NUM_WORDS_DEF,
    parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_cmd                 i_cmd,
    output logic                 o_pop,
    output logic                 o_busy,
    input  logic [15:0]          i_min,
    input  logic [15:0]          i_max,
    output logic                 o_strobe,
    output logic [1:0]           o_status,
    output logic                 o_bit_value,
    output logic [15:0]          o_free_index
);
    localparam int unsigned AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int unsigned CW = $clog2(NUM_WORDS + 1);
    localparam int unsigned BW = $clog2(WORD_BITS);
    localparam logic [WORD_BITS-1:0] ONES = '1;

    t_bk_state        r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [CW-1:0]    r_cur, n_cur;
    logic [CW-1:0]    r_ptr, n_ptr;
    logic [CW-1:0]    r_len, n_len;
    logic             we;
    logic [AW-1:0]    addr;
    logic [WORD_BITS-1:0] wdata, rdata;
    logic             n_strobe;
    logic [1:0]       n_status;
    logic             n_bitv;
    logic [15:0]      n_free;
    logic [15:0]      span;
    logic [15:0]      nw;
    logic [BW-1:0]    j;
    logic [31:0]      idx;

    bba_ram #(.WIDTH(WORD_BITS), .DEPTH(1 << AW)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(wdata), .o_rdata(rdata)
    );

    always_comb begin
        span = i_max - i_min;
        nw = (span >> BW) + 16'd1;
        j = BW'(WORD_BITS - 1);
        for (int k = WORD_BITS - 2; k >= 0; k--) begin
            if (!rdata[k]) begin
                j = BW'(k);
            end
        end
        idx = 32'(r_ptr) * 32'(WORD_BITS) + 32'(j) + 32'(i_min);
    end

    always_comb begin
        n_state = r_state;
        n_cmd = r_cmd;
        n_cur = r_cur;
        n_ptr = r_ptr;
        n_len = r_len;
        o_pop = 1'b0;
        we = 1'b0;
        addr = r_ptr[AW-1:0];
        wdata = rdata;
        n_strobe = 1'b0;
        n_status = ST_OK;
        n_bitv = 1'b0;
        n_free = 16'd0;
        case (r_state)
            BK_CLR: begin
                we = 1'b1;
                wdata = '0;
                n_ptr = r_ptr + 1'b1;
                if (r_ptr == CW'(NUM_WORDS - 1)) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    if (i_min > i_max) begin
                        n_len = '0;
                    end else if ({16'd0, nw} > 32'(NUM_WORDS)) begin
                        n_len = CW'(NUM_WORDS);
                    end else begin
                        n_len = nw[CW-1:0];
                    end
                    if (i_cmd.mode == MODE_FIND) begin
                        n_ptr = r_cur;
                        n_state = BK_RD;
                    end else if (i_cmd.bad) begin
                        n_strobe = 1'b1;
                        n_status = ST_BAD;
                    end else begin
                        n_ptr = CW'(i_cmd.word);
                        n_state = BK_RD;
                    end
                end
            end
            BK_RD: begin
                if (r_cmd.mode == MODE_FIND && r_ptr >= r_len) begin
                    n_cur = r_len;
                    n_strobe = 1'b1;
                    n_status = ST_FULL;
                    n_state = BK_IDLE;
                end else begin
                    n_state = BK_WAIT;
                end
            end
            BK_WAIT: begin
                n_state = (r_cmd.mode == MODE_FIND) ? BK_SCAN : BK_EXEC;
            end
            BK_EXEC: begin
                n_strobe = 1'b1;
                n_state = BK_IDLE;
                case (r_cmd.mode)
                    MODE_GET: n_bitv = rdata[r_cmd.bit_ofs[BW-1:0]];
                    MODE_SET: begin
                        we = 1'b1;
                        wdata[r_cmd.bit_ofs[BW-1:0]] = 1'b1;
                    end
                    default: begin
                        we = 1'b1;
                        wdata[r_cmd.bit_ofs[BW-1:0]] = 1'b0;
                        if (r_ptr < r_cur) begin
                            n_cur = r_ptr;
                        end
                    end
                endcase
            end
            BK_SCAN: begin
                if (rdata == ONES) begin
                    n_ptr = r_ptr + 1'b1;
                    n_state = BK_RD;
                end else begin
                    n_cur = r_ptr;
                    n_strobe = 1'b1;
                    n_state = BK_IDLE;
                    if (idx > 32'(i_max)) begin
                        n_status = ST_FULL;
                    end else begin
                        n_free = idx[15:0];
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_CLR;
            r_cur <= '0;
            r_ptr <= '0;
            o_strobe <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur <= n_cur;
            r_ptr <= n_ptr;
            o_strobe <= n_strobe;
        end
        r_cmd <= n_cmd;
        r_len <= n_len;
        o_status <= n_status;
        o_bit_value <= n_bitv;
        o_free_index <= n_free;
    end

    assign o_busy = (r_state == BK_CLR);
endmodule

// ----- tb/sv/bitmap_block_allocator_core_tb.sv -----
// Self-checking testbench for bitmap_block_allocator_core: drives get, set, clear and
// find requests under several min/max settings and checks every result strobe.
// Depends on bba_pkg and the core RTL.
`timescale 1ns / 100ps

module bitmap_block_allocator_core_tb;
    import bba_pkg::*;

    typedef struct {
        t_status     status;
        logic        bit_value;
        logic [15:0] free_index;
    } t_alloc_result;

    class alloc_scoreboard;
        logic [63:0]   words [64];
        int unsigned   cursor;
        logic [15:0]   lo_idx, hi_idx;
        t_alloc_result pending [$];
        logic [15:0]   last_free;
        int unsigned   errors, checked, n_full, n_bad, n_found;
        int unsigned   per_mode [4];

        function new();
            foreach (words[i]) words[i] = '0;
            cursor = 0;
            lo_idx = MIN_RESET;
            hi_idx = MAX_RESET;
            last_free = '0;
        endfunction

        function void set_reg(t_cfg_idx r, logic [15:0] v);
            if (r == CFG_MIN) lo_idx = v;
            else hi_idx = v;
        endfunction

        function int unsigned words_used();
            int unsigned n;
            if (lo_idx > hi_idx) return 0;
            n = (int'(hi_idx) - int'(lo_idx)) / 64 + 1;
            return (n > 64) ? 64 : n;
        endfunction

        // predict the result of one accepted request and update the bitmap copy
        function void note_request(t_mode m, logic [15:0] x);
            t_alloc_result r;
            int unsigned len, i, j, w, b, idx;
            r.status = ST_OK;
            r.bit_value = 1'b0;
            r.free_index = '0;
            per_mode[m]++;
            if (m == MODE_FIND) begin
                len = words_used();
                i = cursor;
                while (i < len && words[i] == '1) i++;
                if (i >= len) begin
                    cursor = len;
                    r.status = ST_FULL;
                end else begin
                    j = 0;
                    while (j < 63 && words[i][j]) j++;
                    idx = i * 64 + j + lo_idx;
                    cursor = i;
                    if (idx > hi_idx) r.status = ST_FULL;
                    else begin
                        r.free_index = idx[15:0];
                        last_free = idx[15:0];
                    end
                end
            end else if (x < lo_idx || x > hi_idx || (x - lo_idx) / 64 >= 64) begin
                r.status = ST_BAD;
            end else begin
                w = (x - lo_idx) / 64;
                b = (x - lo_idx) % 64;
                case (m)
                    MODE_GET: r.bit_value = words[w][b];
                    MODE_SET: words[w][b] = 1'b1;
                    default: begin
                        words[w][b] = 1'b0;
                        if (w < cursor) cursor = w;
                    end
                endcase
            end
            if (r.status == ST_FULL) n_full++;
            if (r.status == ST_BAD) n_bad++;
            if (r.status == ST_OK && m == MODE_FIND) n_found++;
            pending.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic bv, logic [15:0] fi);
            t_alloc_result e;
            checked++;
            if (pending.size() == 0) begin
                $error("result strobe with no request outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, st);
                errors++;
            end
            if (bv !== e.bit_value) begin
                $error("bit_value: expected %0d, got %0d", e.bit_value, bv);
                errors++;
            end
            if (fi !== e.free_index) begin
                $error("free_index: expected %0d, got %0d", e.free_index, fi);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n, i_start, i_cfg_valid, i_cfg_index;
    logic [1:0]  i_mode;
    logic [15:0] i_index, i_cfg_data;
    logic        o_busy, o_cfg_ready, o_strobe, o_bit_value;
    logic [1:0]  o_status;
    logic [15:0] o_free_index;

    alloc_scoreboard sb = new();
    bit          quiet;
    int unsigned cycles;

    bitmap_block_allocator_core u_top (.*);

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) sb.note_request(t_mode'(i_mode), i_index);
            if (o_strobe) sb.check_result(o_status, o_bit_value, o_free_index);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("bitmap_block_allocator_core_tb: done, errors");
            $finish;
        end
    end

    task automatic send(t_mode m, logic [15:0] x);
        i_start <= 1'b1;
        i_mode  <= m;
        i_index <= x;
        do @(posedge i_clk); while (o_busy);
        if (!quiet && $urandom_range(99) < 24) begin
            i_start <= 1'b0;
            i_mode  <= t_mode'(2'($urandom_range(3)));
            i_index <= 16'($urandom);
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx r, logic [15:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(r, v);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic setup(logic [15:0] lo, logic [15:0] hi);
        drain();
        cfg_write(CFG_MIN, lo);
        cfg_write(CFG_MAX, hi);
    endtask

    function automatic logic [15:0] pick_index();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 10) return 16'($urandom);
        if (k < 15) return 16'(sb.lo_idx - $urandom_range(1, 3));
        if (k < 20) return 16'(sb.hi_idx + $urandom_range(0, 3));
        if (sb.lo_idx > sb.hi_idx) return 16'($urandom);
        return 16'(sb.lo_idx + $urandom_range(0, sb.hi_idx - sb.lo_idx));
    endfunction

    // allocate (find then set the found index), free, and random get/set/find, with noise
    task automatic random_phase(int unsigned n);
        int unsigned k;
        repeat (n) begin
            k = $urandom_range(99);
            if (k < 35) begin
                send(MODE_FIND, 16'($urandom));
                send(MODE_SET, sb.last_free);
            end else if (k < 50) send(MODE_CLEAR, pick_index());
            else if (k < 70) send(MODE_GET, pick_index());
            else if (k < 85) send(MODE_SET, pick_index());
            else send(MODE_FIND, 16'($urandom));
        end
    endtask

    initial begin
        i_rst_n = 1'b0; i_start = 1'b0; i_mode = MODE_GET; i_index = '0;
        i_cfg_valid = 1'b0; i_cfg_index = CFG_MIN; i_cfg_data = '0;
        cycles = 0; quiet = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send(MODE_FIND, 16'hFFFF);
        send(MODE_GET, 16'd0);
        send(MODE_SET, 16'd0);
        send(MODE_GET, 16'd0);
        send(MODE_FIND, 16'd0);
        send(MODE_SET, 16'd4095);
        send(MODE_GET, 16'd4095);
        send(MODE_GET, 16'd4096);
        send(MODE_SET, 16'hFFFF);
        send(MODE_CLEAR, 16'd0);
        send(MODE_FIND, 16'd0);
        send(MODE_CLEAR, 16'hFFFF);
        send(MODE_CLEAR, 16'd4095);
        send(MODE_GET, 16'h5555);
        send(MODE_GET, 16'hAAAA);

        setup(16'd100, 16'd163);
        send(MODE_GET, 16'd99);
        send(MODE_GET, 16'd164);
        random_phase(150);
        quiet = 1'b1;
        random_phase(60);
        drain();
        quiet = 1'b0;
        random_phase(60);

        setup(16'd200, 16'd100);
        random_phase(30);

        setup(16'd65500, 16'd65535);
        random_phase(150);

        setup(16'd5, 16'd5);
        random_phase(40);

        setup(16'd0, 16'd65535);
        random_phase(200);

        setup(16'd1000, 16'd1200);
        random_phase(200);

        setup(16'd7, 16'd170);
        random_phase(250);
        drain();

        $display("requests: get %0d set %0d clear %0d find %0d; results checked %0d",
                 sb.per_mode[0], sb.per_mode[1], sb.per_mode[2], sb.per_mode[3], sb.checked);
        $display("finds ok %0d, full %0d, out-of-range %0d over eight min/max settings",
                 sb.n_found, sb.n_full, sb.n_bad);
        if (sb.errors == 0)
            $display("bitmap_block_allocator_core_tb: done, clean");
        else
            $display("bitmap_block_allocator_core_tb: done, errors");
        $finish;
    end
endmodule

// ----- bitmap_block_allocator_core.f -----
src/bba_pkg.sv
src/bba_ram.sv
src/bba_front.sv
src/bba_back.sv
src/bitmap_block_allocator_core.sv
tb/sv/bitmap_block_allocator_core_tb.sv
